// ===== hdl/pixel_scaled_square_root_defines.svh =====
// Assertion macros shared by the scaled square root design.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef PIXEL_SCALED_SQUARE_ROOT_DEFINES_SVH
`define PIXEL_SCALED_SQUARE_ROOT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold a fixed number of cycles after the antecedent.
`define PSQ_ASSERT_LATER(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== hdl/psqrt_pkg.sv =====
// Package for the scaled square root block: pixel type codes, clip limits, reset values,
// register indexes, root fraction width, per-item sideband struct. No dependencies.
package psqrt_pkg;

  // Pixel type codes held in the pixel_type register.
  localparam logic [2:0] PT_U8  = 3'd0;
  localparam logic [2:0] PT_S8  = 3'd1;
  localparam logic [2:0] PT_U16 = 3'd2;
  localparam logic [2:0] PT_S16 = 3'd3;
  localparam logic [2:0] PT_S32 = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_PIXEL_TYPE = 1'b0;
  localparam logic CFG_SCALE      = 1'b1;

  // Upper clip limits of the narrow types.
  localparam logic [31:0] U8_MAX  = 32'd255;
  localparam logic [31:0] S8_MAX  = 32'd127;
  localparam logic [31:0] U16_MAX = 32'd65535;
  localparam logic [31:0] S16_MAX = 32'd32767;

  // Reset values of the configuration registers.
  localparam logic [2:0]  PIXEL_TYPE_RESET = PT_U8;
  localparam logic [31:0] SCALE_RESET      = 32'd65536;

  // Fraction bits of the square root.
  localparam int ROOT_FRAC_W = 16;

  // Sideband that moves along the pipeline with every item.
  typedef struct packed {
    logic        valid;
    logic        neg;
    logic [31:0] max_value;
  } psqrt_side_t;

endpackage

// ===== hdl/psqrt_root_step.sv =====
// One registered stage of the square root digit recurrence: settles one root bit.
// Depends on psqrt_pkg for the sideband struct.
module psqrt_root_step import psqrt_pkg::*; #(
  parameter int ROOT_W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  psqrt_side_t           side_in,
  input  logic [2*ROOT_W-1:0]   rad_in,
  input  logic [ROOT_W+1:0]     rem_in,
  input  logic [ROOT_W-1:0]     root_in,
  output psqrt_side_t           side_out,
  output logic [2*ROOT_W-1:0]   rad_out,
  output logic [ROOT_W+1:0]     rem_out,
  output logic [ROOT_W-1:0]     root_out
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [REM_W:0]   diff;
  logic             fits;

  // Bring down the next two radicand bits and try the bit set to one.
  always_comb begin
    rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    trial  = {root_in, 2'b01};
    diff   = {1'b0, rem_sh} - {1'b0, trial};
    fits   = ~diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
    side_out.neg       <= side_in.neg;
    side_out.max_value <= side_in.max_value;
    rad_out            <= {rad_in[RAD_W-3:0], 2'b00};
    rem_out            <= fits ? diff[REM_W-1:0] : rem_sh;
    root_out           <= {root_in[ROOT_W-2:0], fits};
  end

endmodule

// ===== hdl/psqrt_root.sv =====
// Pipelined integer square root: a chain of ROOT_W recurrence stages.
// Depends on psqrt_pkg and psqrt_root_step.
module psqrt_root import psqrt_pkg::*; #(
  parameter int ROOT_W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  psqrt_side_t         side_in,
  input  logic [2*ROOT_W-1:0] rad_in,
  output psqrt_side_t         side_out,
  output logic [ROOT_W-1:0]   root_out
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  psqrt_side_t       side_pipe [ROOT_W+1];
  logic [RAD_W-1:0]  rad_pipe  [ROOT_W+1];
  logic [REM_W-1:0]  rem_pipe  [ROOT_W+1];
  logic [ROOT_W-1:0] root_pipe [ROOT_W+1];

  assign side_pipe[0] = side_in;
  assign rad_pipe[0]  = rad_in;
  assign rem_pipe[0]  = '0;
  assign root_pipe[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    psqrt_root_step #(
      .ROOT_W (ROOT_W)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .side_in  (side_pipe[k]),
      .rad_in   (rad_pipe[k]),
      .rem_in   (rem_pipe[k]),
      .root_in  (root_pipe[k]),
      .side_out (side_pipe[k+1]),
      .rad_out  (rad_pipe[k+1]),
      .rem_out  (rem_pipe[k+1]),
      .root_out (root_pipe[k+1])
    );
  end

  assign side_out = side_pipe[ROOT_W];
  assign root_out = root_pipe[ROOT_W];

endmodule

// ===== hdl/psqrt_scale.sv =====
// Scale, round and clip: a registered multiply, then round half up and saturate.
// Depends on psqrt_pkg for the sideband struct and root fraction width.
module psqrt_scale import psqrt_pkg::*; #(
  parameter int ROOT_W    = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  psqrt_side_t        side_in,
  input  logic [ROOT_W-1:0]  root_in,
  input  logic [31:0]        scale,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic               was_clipped,
  output logic               negative_input
);

  localparam int PROD_W = ROOT_W + 32;
  localparam int FB     = ROOT_FRAC_W + FRAC_BITS;
  localparam int RND_W  = PROD_W - FB;
  localparam int CMP_W  = (RND_W > 32) ? RND_W : 32;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FB - 1);

  psqrt_side_t       side_a;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] sum;
  logic [CMP_W-1:0]  rnd_ext;
  logic [CMP_W-1:0]  max_ext;
  logic              over;

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_a.valid <= 1'b0;
    end else begin
      side_a.valid <= side_in.valid;
    end
    side_a.neg       <= side_in.neg;
    side_a.max_value <= side_in.max_value;
    prod             <= PROD_W'(root_in) * PROD_W'(scale);
  end

  // Round half up, then compare against the type limit.
  always_comb begin
    sum     = prod + HALF;
    rnd_ext = CMP_W'(sum[PROD_W-1:FB]);
    max_ext = CMP_W'(side_a.max_value);
    over    = rnd_ext > max_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_a.valid;
    end
    negative_input <= side_a.neg;
    was_clipped    <= ~side_a.neg & over;
    if (side_a.neg) begin
      result_value <= '0;
    end else if (over) begin
      result_value <= side_a.max_value;
    end else begin
      result_value <= rnd_ext[31:0];
    end
  end

endmodule

// ===== hdl/pixel_scaled_square_root.sv =====
// Top level of the scaled square root block: input decode, root pipeline, scaling.
// Depends on psqrt_pkg, psqrt_root, psqrt_scale and the assertion macro header.
`include "pixel_scaled_square_root_defines.svh"

// The block takes one pixel in every clock cycle and returns one result for
// each, in order, at the end of the pipeline: the square root, which settles
// one root bit per pipeline stage, plus one stage that decodes the pixel, one
// for the multiply by the scale and one for rounding and clipping.
// A transfer happens at a clock edge where start is high and busy is low;
// busy is high only while reset is held. The result appears for a single
// cycle with done high, and the receiver has no way to stall it, so it must
// capture result_value, was_clipped and negative_input whenever done is set.
// The configuration registers are written through cfg_write, cfg_index and
// cfg_data and should only change while no transfer is in flight.
module pixel_scaled_square_root import psqrt_pkg::*; #(
  parameter int SCALE_FRAC_BITS = 16,
  parameter int PIXEL_WIDTH     = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pixel_value,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic               was_clipped,
  output logic               negative_input
);

  // Magnitude bits of a non-negative pixel across all types, and the width
  // of the root of that magnitude carrying ROOT_FRAC_W fraction bits.
  localparam int MAG_W   = (PIXEL_WIDTH - 1 > 16) ? PIXEL_WIDTH - 1 : 16;
  localparam int ROOT_W  = (MAG_W + 2 * ROOT_FRAC_W + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int LATENCY = ROOT_W + 3;
  localparam logic [31:0] S32_MAX = 32'((33'd1 << (PIXEL_WIDTH - 1)) - 33'd1);

  // Configuration registers.
  logic [2:0]  pixel_type;
  logic [31:0] scale_q16;

  // Decode stage.
  psqrt_side_t      side_next;
  logic [MAG_W-1:0] mag_next;
  psqrt_side_t      side_dec;
  logic [MAG_W-1:0] mag;
  logic [RAD_W-1:0] rad;

  // Root pipeline outputs.
  psqrt_side_t       side_root;
  logic [ROOT_W-1:0] root;

  // No backpressure: the pipeline advances every cycle.
  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_type <= PIXEL_TYPE_RESET;
      scale_q16  <= SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PIXEL_TYPE: pixel_type <= cfg_data[2:0];
        CFG_SCALE:      scale_q16  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Take only the bits that belong to the configured type. A negative pixel
  // of a signed type keeps a zero magnitude and is flagged; the clip limit
  // rides along with the item so the last stage needs no type decode.
  always_comb begin
    side_next.valid = start & ~busy;
    case (pixel_type)
      PT_U8: begin
        side_next.neg       = 1'b0;
        side_next.max_value = U8_MAX;
        mag_next            = MAG_W'(pixel_value[7:0]);
      end
      PT_S8: begin
        side_next.neg       = pixel_value[7];
        side_next.max_value = S8_MAX;
        mag_next            = MAG_W'(pixel_value[6:0]);
      end
      PT_U16: begin
        side_next.neg       = 1'b0;
        side_next.max_value = U16_MAX;
        mag_next            = MAG_W'(pixel_value[15:0]);
      end
      PT_S16: begin
        side_next.neg       = pixel_value[15];
        side_next.max_value = S16_MAX;
        mag_next            = MAG_W'(pixel_value[14:0]);
      end
      default: begin
        // The full-width signed type; unused codes behave the same way.
        side_next.neg       = pixel_value[PIXEL_WIDTH-1];
        side_next.max_value = S32_MAX;
        mag_next            = MAG_W'(pixel_value[PIXEL_WIDTH-2:0]);
      end
    endcase
    if (side_next.neg) begin
      mag_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_dec.valid <= 1'b0;
    end else begin
      side_dec.valid <= side_next.valid;
    end
    side_dec.neg       <= side_next.neg;
    side_dec.max_value <= side_next.max_value;
    mag                <= mag_next;
  end

  // The radicand is the pixel shifted up by twice the root fraction width,
  // so the integer root carries ROOT_FRAC_W fraction bits.
  assign rad = RAD_W'({mag, {(2 * ROOT_FRAC_W){1'b0}}});

  psqrt_root #(
    .ROOT_W (ROOT_W)
  ) u_root (
    .clk      (clk),
    .rst      (rst),
    .side_in  (side_dec),
    .rad_in   (rad),
    .side_out (side_root),
    .root_out (root)
  );

  psqrt_scale #(
    .ROOT_W    (ROOT_W),
    .FRAC_BITS (SCALE_FRAC_BITS)
  ) u_scale (
    .clk            (clk),
    .rst            (rst),
    .side_in        (side_root),
    .root_in        (root),
    .scale          (scale_q16),
    .done           (done),
    .result_value   (result_value),
    .was_clipped    (was_clipped),
    .negative_input (negative_input)
  );

  // Every transfer yields a result strobe at the end of the pipeline.
  `PSQ_ASSERT_LATER(a_latency, start && !busy, LATENCY, done, "missing result strobe")
  // A negative pixel always gives a zero result that is not marked clipped.
  `PSQ_ASSERT_NOW(a_neg_zero, done && negative_input, result_value == 0 && !was_clipped, "bad neg")
  // The scaled root is never negative.
  `PSQ_ASSERT_NOW(a_nonneg, done, !result_value[31], "negative result value")

endmodule
